/* src/ibb_pkg.sv */
`default_nettype none

package ibb_pkg;

   localparam int SAMPLE_W     = 8;
   localparam int ROW_W        = 16;
   localparam int SUM_W        = 16;
   localparam int RECIP_W      = 25;
   localparam int RECIP_SHIFT  = 24;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 16;
   localparam int CHAN_REG_W   = 3;
   localparam int BIN_REG_W    = 5;
   localparam int OUT_DEPTH    = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_SIZE      = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } ibb_div_status_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
   } ibb_result_type;

   // Reciprocal of bin*bin, rounded up, scaled by 2^24. A 16-bit sum times this
   // value shifted right by 24 is exactly the floor of sum / (bin*bin).
   function automatic logic [RECIP_W-1:0] ibb_recip(input logic [BIN_REG_W-1:0] bin);
      logic [RECIP_W-1:0] r;
      unique case (bin)
         5'd1:    r = 25'd16777216;
         5'd2:    r = 25'd4194304;
         5'd3:    r = 25'd1864136;
         5'd4:    r = 25'd1048576;
         5'd5:    r = 25'd671089;
         5'd6:    r = 25'd466034;
         5'd7:    r = 25'd342393;
         5'd8:    r = 25'd262144;
         5'd9:    r = 25'd207127;
         5'd10:   r = 25'd167773;
         5'd11:   r = 25'd138655;
         5'd12:   r = 25'd116509;
         5'd13:   r = 25'd99274;
         5'd14:   r = 25'd85599;
         5'd15:   r = 25'd74566;
         5'd16:   r = 25'd65536;
         default: r = 25'd16777216;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/image_block_binning_core.sv */
`default_nettype none

// Box-average image binning. Samples arrive one channel value per transfer in
// raster order with channels interleaved; every bin_size by bin_size block of
// pixels becomes one output pixel whose channels carry the truncated block
// average, and the final output sample of an image is marked with
// rsp_last_of_image. Partial blocks at the right and bottom edges are dropped.
// The block takes one sample per clock; a four-entry output queue lets input
// keep flowing while the consumer stalls, and apart from a bin_size write,
// input is held off only when that queue plus the results still in the
// pipeline would fill it. Per-column sums live in one synchronous RAM
// (MAX_WIDTH * MAX_CHANNELS words of 16 bits) that is read on input transfer,
// updated in the cycle after and written back, with the last write forwarded
// when the next sample hits the same word. Writing bin_size makes req_ready
// drop while two one-bit-per-cycle dividers re-derive the position within the
// current block. The other registers take effect on the next sample. Register
// values out of range are clamped: zero counts as one, and values above the
// maximums count as the maximums. frame_start on a sample restarts the image
// at that sample.

module image_block_binning_core #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_BIN      = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ibb_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ibb_pkg::SAMPLE_W-1:0]     rsp_binned_value,
   output logic                             rsp_last_of_image,
   input  logic                             csr_write_enable,
   input  logic [ibb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ibb_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   import ibb_pkg::*;

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int XP     = WW + 2;
   localparam int YP     = ROW_W + 2;
   localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CSW    = $clog2(MAX_CHANNELS + 1);
   localparam int BW     = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
   localparam int BSW    = $clog2(MAX_BIN + 1);
   localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
   localparam int AW     = $clog2(DEPTH);
   localparam int RES_W  = $clog2(OUT_DEPTH + 1);
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int QW     = PROD_W - RECIP_SHIFT;

   // Configuration registers.
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [CHAN_REG_W-1:0]   chan_ff;
   logic [BIN_REG_W-1:0]    bin_ff;

   // Clamped configuration.
   logic [WW-1:0]    w_clamp;
   logic [ROW_W-1:0] h_clamp;
   logic [CSW-1:0]   ch_clamp;
   logic [BSW-1:0]   b_clamp;
   logic [RECIP_W-1:0] recip_ff;

   // Position: column, offset in block, block column, row, row offset, channel.
   logic [XW-1:0]    x_ff, x_in;
   logic [BW-1:0]    dx_ff, dx_in;
   logic [XW-1:0]    nx_ff, nx_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic [BW-1:0]    dy_ff, dy_in;
   logic [CW-1:0]    c_ff, c_in;

   logic [XW-1:0]    x_cur, nx_cur;
   logic [BW-1:0]    dx_cur, dy_cur;
   logic [ROW_W-1:0] y_cur;
   logic [CW-1:0]    c_cur;

   logic [XP-1:0]    x_blk_end;
   logic [YP-1:0]    y_blk_end;
   logic [CSW-1:0]   c_inc;
   logic [WW-1:0]    x_inc;
   logic [ROW_W:0]   y_inc;
   logic [BSW-1:0]   dx_inc, dy_inc;
   logic             in_block, is_first, is_produce, is_last;
   logic [AW-1:0]    sum_addr;
   logic             accept, pop;

   // Re-derivation of block offsets after a bin_size write.
   logic               resync_start_ff;
   logic               resync_busy;
   ibb_div_status_type x_div_status, y_div_status;
   logic [XW-1:0]      x_div_quo;
   logic [BSW-1:0]     x_div_rem, y_div_rem;

   // Read-modify-write stage.
   logic                s1_valid_ff;
   logic [AW-1:0]       s1_addr_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_first_ff, s1_produce_ff, s1_last_ff;
   logic [SUM_W-1:0]    ram_rd_data, s1_base, s1_sum;
   logic                fwd_valid_ff;
   logic [AW-1:0]       fwd_addr_ff;
   logic [SUM_W-1:0]    fwd_data_ff;

   // Averaging stage.
   logic                s2_valid_ff, s2_last_ff;
   logic [PROD_W-1:0]   s2_prod_ff;
   logic [QW-1:0]       s2_quo;
   ibb_result_type      s2_result, head;

   logic [RES_W-1:0]    res_ff, res_in;

   // ------------------------------------------------------------------
   // Configuration port and clamping.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= WIDTH_REG_W'(640);
         height_ff       <= HEIGHT_REG_W'(480);
         chan_ff         <= CHAN_REG_W'(3);
         bin_ff          <= BIN_REG_W'(4);
         resync_start_ff <= 1'b0;
      end else begin
         resync_start_ff <= csr_write_enable && (csr_index == CSR_BIN_SIZE);
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data[HEIGHT_REG_W-1:0];
               CSR_CHANNEL_COUNT: chan_ff   <= csr_write_data[CHAN_REG_W-1:0];
               CSR_BIN_SIZE:      bin_ff    <= csr_write_data[BIN_REG_W-1:0];
            endcase
         end
      end
      recip_ff <= ibb_recip(BIN_REG_W'(b_clamp));
   end

   always_comb begin
      priority if (width_ff == '0) begin
         w_clamp = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_clamp = WW'(MAX_WIDTH);
      end else begin
         w_clamp = WW'(width_ff);
      end
      h_clamp = (height_ff == '0) ? ROW_W'(1) : height_ff;
      priority if (chan_ff == '0) begin
         ch_clamp = CSW'(1);
      end else if (32'(chan_ff) > 32'(MAX_CHANNELS)) begin
         ch_clamp = CSW'(MAX_CHANNELS);
      end else begin
         ch_clamp = CSW'(chan_ff);
      end
      priority if (bin_ff == '0) begin
         b_clamp = BSW'(1);
      end else if (32'(bin_ff) > 32'(MAX_BIN)) begin
         b_clamp = BSW'(MAX_BIN);
      end else begin
         b_clamp = BSW'(bin_ff);
      end
   end

   // ------------------------------------------------------------------
   // Offset re-derivation: column and row divided by the new bin size.
   // ------------------------------------------------------------------
   ibb_divider #(.NUM_W(XW), .DEN_W(BSW)) u_x_div (
      .clock       (clock),
      .reset       (reset),
      .start       (resync_start_ff),
      .numerator   (x_ff),
      .denominator (b_clamp),
      .status      (x_div_status),
      .quotient    (x_div_quo),
      .remainder   (x_div_rem)
   );

   ibb_divider #(.NUM_W(ROW_W), .DEN_W(BSW)) u_y_div (
      .clock       (clock),
      .reset       (reset),
      .start       (resync_start_ff),
      .numerator   (y_ff),
      .denominator (b_clamp),
      .status      (y_div_status),
      .quotient    (),
      .remainder   (y_div_rem)
   );

   assign resync_busy = resync_start_ff || x_div_status.busy || x_div_status.done ||
                        y_div_status.busy || y_div_status.done;

   // ------------------------------------------------------------------
   // Input side: classify the sample and advance the position.
   // ------------------------------------------------------------------
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = !resync_busy && (res_ff < RES_W'(OUT_DEPTH));

   always_comb begin
      // A frame start places this sample at the origin.
      x_cur  = req_frame_start ? '0 : x_ff;
      dx_cur = req_frame_start ? '0 : dx_ff;
      nx_cur = req_frame_start ? '0 : nx_ff;
      y_cur  = req_frame_start ? '0 : y_ff;
      dy_cur = req_frame_start ? '0 : dy_ff;
      c_cur  = req_frame_start ? '0 : c_ff;

      // The block holding this sample is whole when its right and bottom
      // edges stay inside the image; it is the last one when the next would not.
      x_blk_end  = XP'(x_cur) - XP'(dx_cur) + XP'(b_clamp);
      y_blk_end  = YP'(y_cur) - YP'(dy_cur) + YP'(b_clamp);
      c_inc      = CSW'(c_cur) + 1'b1;
      dx_inc     = BSW'(dx_cur) + 1'b1;
      dy_inc     = BSW'(dy_cur) + 1'b1;
      in_block   = (x_blk_end <= XP'(w_clamp)) && (y_blk_end <= YP'(h_clamp)) &&
                   (CSW'(c_cur) < ch_clamp);
      is_first   = (dx_cur == '0) && (dy_cur == '0);
      is_produce = in_block && (dx_inc == b_clamp) && (dy_inc == b_clamp);
      is_last    = ((x_blk_end + XP'(b_clamp)) > XP'(w_clamp)) &&
                   ((y_blk_end + YP'(b_clamp)) > YP'(h_clamp)) &&
                   (c_inc == ch_clamp);
      sum_addr   = AW'(32'(nx_cur) * MAX_CHANNELS + 32'(c_cur));
      x_inc      = WW'(x_cur) + 1'b1;
      y_inc      = (ROW_W + 1)'(y_cur) + 1'b1;

      x_in  = x_ff;
      dx_in = dx_ff;
      nx_in = nx_ff;
      y_in  = y_ff;
      dy_in = dy_ff;
      c_in  = c_ff;

      if (accept) begin
         x_in  = x_cur;
         dx_in = dx_cur;
         nx_in = nx_cur;
         y_in  = y_cur;
         dy_in = dy_cur;
         c_in  = CW'(c_inc);
         if (c_inc >= ch_clamp) begin
            c_in = '0;
            if (x_inc >= w_clamp) begin
               x_in  = '0;
               dx_in = '0;
               nx_in = '0;
               if (y_inc >= (ROW_W + 1)'(h_clamp)) begin
                  y_in  = '0;
                  dy_in = '0;
               end else begin
                  y_in  = ROW_W'(y_inc);
                  dy_in = (dy_inc >= b_clamp) ? '0 : BW'(dy_inc);
               end
            end else begin
               x_in = XW'(x_inc);
               if (dx_inc >= b_clamp) begin
                  dx_in = '0;
                  nx_in = nx_cur + 1'b1;
               end else begin
                  dx_in = BW'(dx_inc);
               end
            end
         end
      end else begin
         if (x_div_status.done) begin
            nx_in = x_div_quo;
            dx_in = BW'(x_div_rem);
         end
         if (y_div_status.done) begin
            dy_in = BW'(y_div_rem);
         end
      end

      // Output slots promised to samples that complete a block.
      res_in = res_ff + RES_W'(accept && is_produce) - RES_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         dx_ff       <= '0;
         nx_ff       <= '0;
         y_ff        <= '0;
         dy_ff       <= '0;
         c_ff        <= '0;
         res_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         x_ff        <= x_in;
         dx_ff       <= dx_in;
         nx_ff       <= nx_in;
         y_ff        <= y_in;
         dy_ff       <= dy_in;
         c_ff        <= c_in;
         res_ff      <= res_in;
         s1_valid_ff <= accept && in_block;
      end
      if (accept) begin
         s1_addr_ff    <= sum_addr;
         s1_sample_ff  <= req_sample;
         s1_first_ff   <= is_first;
         s1_produce_ff <= is_produce;
         s1_last_ff    <= is_last;
      end
   end

   // ------------------------------------------------------------------
   // Column sum RAM: read on transfer, accumulate and write in the cycle after.
   // ------------------------------------------------------------------
   ibb_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sum),
      .rd_en   (accept),
      .rd_addr (sum_addr),
      .rd_data (ram_rd_data)
   );

   // The RAM returns old data when the word was written at the same edge it was
   // read, so the most recent write is forwarded whenever the address matches.
   always_comb begin
      s1_base = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rd_data;
      s1_sum  = s1_first_ff ? SUM_W'(s1_sample_ff) : s1_base + SUM_W'(s1_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            fwd_valid_ff <= 1'b1;
         end
         s2_valid_ff <= s1_valid_ff && s1_produce_ff;
      end
      if (s1_valid_ff) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= s1_sum;
      end
      s2_prod_ff <= PROD_W'(s1_sum) * PROD_W'(recip_ff);
      s2_last_ff <= s1_last_ff;
   end

   // ------------------------------------------------------------------
   // Average: scaled product shifted down, saturated to a byte.
   // ------------------------------------------------------------------
   always_comb begin
      s2_quo          = s2_prod_ff[PROD_W-1:RECIP_SHIFT];
      s2_result.value = (s2_quo > QW'(255)) ? SAMPLE_W'(255) : s2_quo[SAMPLE_W-1:0];
      s2_result.last  = s2_last_ff;
   end

   ibb_out_fifo #(.DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (s2_result),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (head)
   );

   assign rsp_binned_value  = head.value;
   assign rsp_last_of_image = head.last;

endmodule

`default_nettype wire

/* src/ibb_ram.sv */
`default_nettype none

module ibb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/ibb_divider.sv */
`default_nettype none

module ibb_divider #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            numerator,
   input  logic [DEN_W-1:0]            denominator,
   output ibb_pkg::ibb_div_status_type status,
   output logic [NUM_W-1:0]            quotient,
   output logic [DEN_W-1:0]            remainder
);

   import ibb_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      trial    = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(NUM_W);
         num_in   = numerator;
         rem_in   = '0;
         den_in   = denominator;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(trial);
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

/* src/ibb_out_fifo.sv */
`default_nettype none

module ibb_out_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ibb_pkg::ibb_result_type push_data,
   input  logic                    pop,
   output logic                    out_valid,
   output ibb_pkg::ibb_result_type out_data
);

   import ibb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ibb_result_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* src/ibb_checker.sv */
`default_nettype none

module ibb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ibb_pkg::SAMPLE_W-1:0]     rsp_binned_value,
   input logic                             rsp_last_of_image,
   input logic                             csr_write_enable,
   input logic [ibb_pkg::CSR_INDEX_W-1:0]  csr_index
);

   import ibb_pkg::*;

   // Reset empties the output queue.
   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Out of reset nothing holds input back.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

   // A new bin size must re-derive block offsets before any sample is taken.
   a_bin_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && (csr_index == CSR_BIN_SIZE)) |=> !req_ready)
      else $error("sample taken while block offsets are re-derived");

   // A stalled result stays offered and unchanged.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_binned_value) && $stable(rsp_last_of_image)))
      else $error("stalled result changed or dropped");

endmodule

bind image_block_binning_core ibb_checker u_ibb_checker (.*);

`default_nettype wire

/* bench/image_block_binning_core_test.sv */
`default_nettype none

module image_block_binning_core_test;
   import ibb_pkg::*;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_BIN      = 16;

   // A final block that produced nothing may still be in flight after the last
   // result; the settling wait covers it.
   localparam int IDLE_SETTLE = 8;
   localparam int RANDOM_SAMPLE_GOAL = 1050;
   // The slowest correct run, with every gap and stall at its longest, stays well
   // under a third of this timeout.
   localparam longint TIMEOUT_TIME = 64'd6_000_000;

   typedef struct {
      logic [SAMPLE_W-1:0] value;
      logic                frame_start;
   } pixel_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_binned_value;
   logic                   rsp_last_of_image;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Samples waiting to go out, and block averages the block still owes us.
   pixel_sample_type samples_to_send[$];
   ibb_result_type   averages_due[$];

   // Our own copy of the register file, starting from the reset values.
   logic [WIDTH_REG_W-1:0]  cfg_width    = 12'd640;
   logic [HEIGHT_REG_W-1:0] cfg_height   = 16'd480;
   logic [CHAN_REG_W-1:0]   cfg_channels = 3'd3;
   logic [BIN_REG_W-1:0]    cfg_bin      = 5'd4;

   // Running block sums, one per output column and channel, plus the raster
   // position of the next sample.
   logic [SUM_W-1:0] column_sum [0:MAX_WIDTH*MAX_CHANNELS-1];
   logic [10:0]      col_pos  = '0;
   logic [15:0]      row_pos  = '0;
   logic [1:0]       chan_pos = '0;

   int unsigned mismatch_count = 0;
   int unsigned random_samples_queued = 0;

   // Per-item gaps on each side; a burst flag turns the gaps off for a stretch.
   int unsigned      send_gap = 0;
   int unsigned      take_gap = 0;
   bit               send_burst = 1'b0;
   bit               take_burst = 1'b0;
   pixel_sample_type next_sample;
   ibb_result_type   oldest_due;

   image_block_binning_core #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_CHANNELS(MAX_CHANNELS),
      .MAX_BIN     (MAX_BIN)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_binned_value (rsp_binned_value),
      .rsp_last_of_image(rsp_last_of_image),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Advances the reference state by one accepted sample. The first sample of
   // a block overwrites its column sum, the others add to it, and the bottom
   // right sample of the block yields the truncated average. Samples outside
   // the whole blocks, or at a position left over from a register change, are
   // dropped but still move the position on.
   function automatic void predict_binned_average(input logic [SAMPLE_W-1:0] value,
                                                  input logic frame_start);
      int unsigned w, h, ch, b, blocks_x, blocks_y, x, y, c, sum, avg, slot;
      ibb_result_type due;
      w  = clamp_to(cfg_width, 1, MAX_WIDTH);
      h  = clamp_to(cfg_height, 1, 65535);
      ch = clamp_to(cfg_channels, 1, MAX_CHANNELS);
      b  = clamp_to(cfg_bin, 1, MAX_BIN);
      blocks_x = w / b;
      blocks_y = h / b;
      if (frame_start) begin
         col_pos  = '0;
         row_pos  = '0;
         chan_pos = '0;
      end
      x = col_pos;
      y = row_pos;
      c = chan_pos;
      if (x < blocks_x * b && y < blocks_y * b && c < ch) begin
         slot = (x / b) * MAX_CHANNELS + c;
         if (x % b == 0 && y % b == 0) begin
            sum = value;
         end else begin
            sum = (column_sum[slot] + value) & 32'hFFFF;
         end
         column_sum[slot] = sum[15:0];
         if (x % b == b - 1 && y % b == b - 1) begin
            // An average above 255 can only come from a bin change mid-image.
            avg = sum / (b * b);
            due.value = (avg > 255) ? 8'd255 : avg[7:0];
            due.last  = (y / b == blocks_y - 1) && (x / b == blocks_x - 1) && (c == ch - 1);
            averages_due.push_back(due);
         end
      end
      c++;
      if (c >= ch) begin
         c = 0;
         x++;
         if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) begin
               y = 0;
            end
         end
      end
      chan_pos = c[1:0];
      col_pos  = x[10:0];
      row_pos  = y[15:0];
   endfunction

   // Sample driver. The prediction is made at the edge that accepts the
   // transfer, so it always sees the register settings in force at that time.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = $urandom_range(0, 14);
      end else begin
         if (req_valid && req_ready) begin
            predict_binned_average(req_sample, req_frame_start);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
               next_sample = samples_to_send.pop_front();
               req_valid       <= 1'b1;
               req_sample      <= next_sample.value;
               req_frame_start <= next_sample.frame_start;
               if ($urandom_range(0, 31) == 0) begin
                  send_burst = !send_burst;
               end
               send_gap = send_burst ? 0 : $urandom_range(0, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Each accepted transfer is checked against the oldest
   // outstanding average; ready then drops for a freshly drawn stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = $urandom_range(0, 14);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (averages_due.size() == 0) begin
               $display("%0t: result with none expected: value %0d last %0b", $time,
                        rsp_binned_value, rsp_last_of_image);
               mismatch_count++;
            end else begin
               oldest_due = averages_due.pop_front();
               if (rsp_binned_value !== oldest_due.value) begin
                  $display("%0t: binned_value expected %0d actual %0d", $time,
                           oldest_due.value, rsp_binned_value);
                  mismatch_count++;
               end
               if (rsp_last_of_image !== oldest_due.last) begin
                  $display("%0t: last_of_image expected %0b actual %0b", $time,
                           oldest_due.last, rsp_last_of_image);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 31) == 0) begin
               take_burst = !take_burst;
            end
            take_gap = take_burst ? 0 : $urandom_range(0, 14);
         end else if (take_gap != 0) begin
            take_gap--;
         end
         rsp_ready <= (take_gap == 0);
      end
   end

   function automatic void push_sample(input logic [SAMPLE_W-1:0] value,
                                       input logic frame_start);
      pixel_sample_type s;
      s.value = value;
      s.frame_start = frame_start;
      samples_to_send.push_back(s);
   endfunction

   // Random content for one sample: mostly noise, sometimes flat white or black
   // images so the sums reach their extremes. A stray frame start now and then
   // restarts the image in the middle. Once the goal is reached nothing more
   // is queued, so the last image may stop part way.
   function automatic void queue_random_sample(input int unsigned style, input logic frame_start);
      logic [SAMPLE_W-1:0] value;
      if (random_samples_queued >= RANDOM_SAMPLE_GOAL) begin
         return;
      end
      if (style == 8) begin
         value = 8'hFF;
      end else if (style == 9) begin
         value = 8'h00;
      end else begin
         value = SAMPLE_W'($urandom_range(0, 255));
      end
      push_sample(value, frame_start || ($urandom_range(0, 255) == 0));
      random_samples_queued++;
   endfunction

   // Blocks until every sample has been sent and every average has come back,
   // then lets the pipeline settle.
   task automatic wait_until_idle();
      while (samples_to_send.size() != 0 || req_valid || averages_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_IMAGE_WIDTH:   cfg_width    = data[WIDTH_REG_W-1:0];
         CSR_IMAGE_HEIGHT:  cfg_height   = data[HEIGHT_REG_W-1:0];
         CSR_CHANNEL_COUNT: cfg_channels = data[CHAN_REG_W-1:0];
         default:           cfg_bin      = data[BIN_REG_W-1:0];
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] width,
                               input logic [CSR_DATA_W-1:0] height,
                               input logic [CSR_DATA_W-1:0] channels,
                               input logic [CSR_DATA_W-1:0] bin);
      wait_until_idle();
      write_register(CSR_IMAGE_WIDTH, width);
      write_register(CSR_IMAGE_HEIGHT, height);
      write_register(CSR_CHANNEL_COUNT, channels);
      write_register(CSR_BIN_SIZE, bin);
   endtask

   // One random setting followed by one or two whole images, a partial image,
   // or an image interrupted by a shrinking register write. Most settings keep
   // the image small so that many complete frames go through; now and then a
   // register takes a value from its whole field, clamps included.
   task automatic run_random_phase();
      int unsigned roll, bin_reg, width_reg, height_reg, chan_reg;
      int unsigned bin_eff, width_eff, height_eff, chan_eff, image_len;
      int unsigned style, n, i;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         bin_reg = $urandom_range(1, 4);
      end else if (roll < 90) begin
         bin_reg = $urandom_range(5, 16);
      end else if (roll < 95) begin
         bin_reg = 0;
      end else begin
         bin_reg = $urandom_range(17, 31);
      end
      bin_eff = clamp_to(bin_reg, 1, MAX_BIN);
      if ($urandom_range(0, 9) == 0) begin
         chan_reg = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
      end else begin
         chan_reg = $urandom_range(1, 4);
      end
      if (bin_eff > 8) begin
         // Large blocks: one block per frame, a few spare columns and rows.
         chan_reg   = $urandom_range(1, 2);
         width_reg  = bin_eff + $urandom_range(0, 2);
         height_reg = bin_eff + $urandom_range(0, 2);
      end else begin
         width_reg  = bin_eff * $urandom_range(1, 4) + $urandom_range(0, bin_eff - 1);
         height_reg = bin_eff * $urandom_range(1, 2) + $urandom_range(0, bin_eff - 1);
      end
      if ($urandom_range(0, 11) == 0) begin
         width_reg = $urandom_range(0, 4095);
      end
      if ($urandom_range(0, 11) == 0) begin
         height_reg = $urandom_range(0, 65535);
      end
      // Bits above each register's width are noise that the block must drop.
      set_geometry(CSR_DATA_W'(width_reg | ($urandom_range(0, 15) << WIDTH_REG_W)),
                   CSR_DATA_W'(height_reg),
                   CSR_DATA_W'(chan_reg | ($urandom_range(0, 8191) << CHAN_REG_W)),
                   CSR_DATA_W'(bin_reg | ($urandom_range(0, 2047) << BIN_REG_W)));
      width_eff  = clamp_to(width_reg, 1, MAX_WIDTH);
      height_eff = clamp_to(height_reg, 1, 65535);
      chan_eff   = clamp_to(chan_reg, 1, MAX_CHANNELS);
      image_len  = width_eff * height_eff * chan_eff;
      style = $urandom_range(0, 9);
      if (image_len > 700) begin
         n = $urandom_range(20, 150);
         for (i = 0; i < n; i++) begin
            queue_random_sample(style, i == 0);
         end
      end else if (image_len > 1 && $urandom_range(0, 5) == 0) begin
         // Stop part way, shrink one dimension, and carry on without a frame
         // start. The position may now lie outside the image, and then the
         // samples are dropped until it wraps. Only shrinking keeps every sum
         // that is read one written earlier in this frame.
         n = $urandom_range(1, image_len - 1);
         for (i = 0; i < n; i++) begin
            queue_random_sample(style, i == 0);
         end
         wait_until_idle();
         case ($urandom_range(0, 2))
            0:       write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(1, width_eff)));
            1:       write_register(CSR_IMAGE_HEIGHT,
                                    CSR_DATA_W'($urandom_range(1, height_eff)));
            default: write_register(CSR_CHANNEL_COUNT,
                                    CSR_DATA_W'($urandom_range(1, chan_eff)));
         endcase
         n = $urandom_range(5, image_len);
         for (i = 0; i < n; i++) begin
            queue_random_sample(style, 1'b0);
         end
      end else begin
         // The second frame sometimes relies on the position wrapping by itself.
         n = image_len * $urandom_range(1, 2) + $urandom_range(0, image_len / 2);
         for (i = 0; i < n; i++) begin
            queue_random_sample(style, i == 0 || (i == image_len && $urandom_range(0, 1) == 1));
         end
      end
   endtask

   initial begin
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every register at zero clamps to a one by one image of one channel
      // with one-pixel blocks: each sample is its own average and ends a frame.
      set_geometry(16'd0, 16'd0, 16'd0, 16'd0);
      push_sample(8'h00, 1'b1);
      push_sample(8'hFF, 1'b0);
      push_sample(8'h5A, 1'b0);

      // Four channels, one-pixel blocks: the full channel range and alternating
      // bit patterns pass straight through. The last sample opens a new frame
      // purely by the position wrapping.
      set_geometry(16'd2, 16'd1, 16'd4, 16'd1);
      push_sample(8'h00, 1'b1);
      push_sample(8'hFF, 1'b0);
      push_sample(8'h55, 1'b0);
      push_sample(8'hAA, 1'b0);
      push_sample(8'h0F, 1'b0);
      push_sample(8'hF0, 1'b0);
      push_sample(8'h01, 1'b0);
      push_sample(8'h80, 1'b0);
      push_sample(8'h7E, 1'b0);

      // Widest and tallest image, maximum channels: register values above the
      // limits must clamp, and the first samples still come straight out.
      set_geometry(16'hFFFF, 16'hFFFF, 16'd4, 16'd1);
      for (i = 0; i < 5; i++) begin
         push_sample(SAMPLE_W'($urandom_range(0, 255)), i == 0);
      end

      // An image smaller than one block never yields a result. The bin and
      // channel values here also clamp to sixteen and four.
      set_geometry(16'd5, 16'd20, 16'd7, 16'd31);
      push_sample(8'hFF, 1'b1);
      push_sample(8'h00, 1'b0);
      push_sample(8'hFF, 1'b0);

      // Saturation: fill part of a sixteen-pixel block with white, then cut the
      // bin to two in mid-image. The next block end reads the oversized sum and
      // its average must clip at 255. The two-pixel frame first makes sure the
      // neighboring column's sum holds a known value.
      set_geometry(16'd2, 16'd1, 16'd1, 16'd1);
      push_sample(8'hFF, 1'b1);
      push_sample(8'hFF, 1'b0);
      set_geometry(16'd16, 16'd16, 16'd1, 16'd16);
      for (i = 0; i < 17; i++) begin
         push_sample(8'hFF, i == 0);
      end
      wait_until_idle();
      write_register(CSR_BIN_SIZE, 16'd2);
      push_sample(8'hFF, 1'b0);
      push_sample(8'hFF, 1'b0);
      push_sample(8'hFF, 1'b0);

      while (random_samples_queued < RANDOM_SAMPLE_GOAL) begin
         run_random_phase();
      end

      wait_until_idle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_TIME);
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
src/ibb_pkg.sv
src/ibb_ram.sv
src/ibb_divider.sv
src/ibb_out_fifo.sv
src/image_block_binning_core.sv
src/ibb_checker.sv
bench/image_block_binning_core_test.sv
